### rtl/odo_pkg.sv
// Shared types, constants and helper functions for the wheel odometry block.
// No dependencies; imported by odo_div and differential_wheel_odometry.
package odo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
    localparam logic signed [31:0] TWO_PI_Q24  = 32'sd105414357;
    localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_SET  = 2'd1;
    localparam logic [1:0] KIND_CLR  = 2'd2;

    localparam logic [7:0] CFG_WHEELBASE     = 8'd0;
    localparam logic [7:0] CFG_COUNT_TO_INCH = 8'd1;

    localparam logic [30:0] WHEELBASE_RST     = 31'd983040;
    localparam logic [24:0] COUNT_TO_INCH_RST = 25'd36603;

    localparam int DIV_NW = 64;
    localparam int DIV_DW = 40;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] left_front_count;
        logic signed [31:0] left_back_count;
        logic signed [31:0] right_front_count;
        logic signed [31:0] right_back_count;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_heading;
    } t_odo_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
    } t_odo_out;

    typedef struct packed {
        logic                      start;
        logic signed [DIV_NW-1:0]  num;
        logic signed [DIV_DW:0]    den;
    } t_div_req;

    typedef struct packed {
        logic                      done;
        logic signed [DIV_NW-1:0]  quot;
        logic signed [DIV_DW:0]    rem;
    } t_div_rsp;

    function automatic logic signed [25:0] atan_step(input logic [4:0] i);
        logic signed [25:0] v;
        case (i)
            5'd0:    v = 26'sd13176795;
            5'd1:    v = 26'sd7778716;
            5'd2:    v = 26'sd4110060;
            5'd3:    v = 26'sd2086331;
            5'd4:    v = 26'sd1047214;
            5'd5:    v = 26'sd524117;
            5'd6:    v = 26'sd262123;
            5'd7:    v = 26'sd131070;
            5'd8:    v = 26'sd65536;
            5'd9:    v = 26'sd32768;
            5'd10:   v = 26'sd16384;
            5'd11:   v = 26'sd8192;
            default: v = (i <= 5'd24) ? (26'sd1 <<< (5'd24 - i)) : 26'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/odo_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on odo_pkg for the request and response structs.
module odo_div import odo_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_d;
    logic              r_qneg;
    logic              r_rneg;

    logic [DIV_DW:0]   sh;
    logic [DIV_DW:0]   diff;
    logic              take;
    logic [DIV_NW-1:0] num_mag;
    logic [DIV_DW:0]   den_mag;

    assign sh      = {r_rem, r_q[DIV_NW-1]};
    assign diff    = sh - {1'b0, r_d};
    assign take    = (sh >= {1'b0, r_d});
    assign num_mag = i_req.num[DIV_NW-1] ? DIV_NW'(-i_req.num) : DIV_NW'(i_req.num);
    assign den_mag = i_req.den[DIV_DW] ? (DIV_DW+1)'(-i_req.den) : (DIV_DW+1)'(i_req.den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q    <= num_mag;
            r_d    <= den_mag[DIV_DW-1:0];
            r_rem  <= '0;
            r_qneg <= i_req.num[DIV_NW-1] ^ i_req.den[DIV_DW];
            r_rneg <= i_req.num[DIV_NW-1];
        end else if (r_busy) begin
            r_rem <= take ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
            r_q   <= {r_q[DIV_NW-2:0], take};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_qneg ? -$signed(r_q) : $signed(r_q);
    assign o_rsp.rem  = r_rneg ? -$signed({1'b0, r_rem}) : $signed({1'b0, r_rem});

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start && r_cnt == CW'(DIV_NW - 1)) |=> (r_done && !r_busy))
        else $error("divider missed completion");

endmodule

### rtl/differential_wheel_odometry.sv
// Channel   Direction  Handshake          Payload
// input     in         i_in_valid/o_in_stall    t_odo_in  (tick, set pose, reset)
// output    out        o_out_valid/i_out_stall  t_odo_out (pose after the item)
// config    in         i_cfg_valid/o_cfg_ready  index 0 wheelbase, 1 count_to_inch
// One item at a time. Set pose, reset and unused kinds go straight to the output state.
// A straight tick runs one division and one sine/cosine, a turning tick two of
// each: each division holds the bit-serial divider until it is done, and
// each sine/cosine needs compare-subtract angle reduction and
// CORDIC_STEPS rotations.
// Reset is synchronous; a stalled result holds the sequencer in its final state.
// Depends on odo_pkg and odo_div.
module differential_wheel_odometry import odo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_odo_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_odo_out    o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IW = $clog2(CORDIC_STEPS);

    localparam logic [34:0] TWO_PI_W = 35'(TWO_PI_Q24);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_AVG       = 5'd1;
    localparam logic [4:0] S_MUL_L     = 5'd2;
    localparam logic [4:0] S_MUL_R     = 5'd3;
    localparam logic [4:0] S_DIST_R    = 5'd4;
    localparam logic [4:0] S_ARC_GO    = 5'd5;
    localparam logic [4:0] S_ARC_WAIT  = 5'd6;
    localparam logic [4:0] S_ANGLE     = 5'd7;
    localparam logic [4:0] S_TRIG_GO   = 5'd8;
    localparam logic [4:0] S_TRIG_WAIT = 5'd9;
    localparam logic [4:0] S_CORDIC    = 5'd10;
    localparam logic [4:0] S_TRIG_END  = 5'd11;
    localparam logic [4:0] S_CH_MUL    = 5'd12;
    localparam logic [4:0] S_CH_GO     = 5'd13;
    localparam logic [4:0] S_CH_WAIT   = 5'd14;
    localparam logic [4:0] S_POSE_TRIG = 5'd15;
    localparam logic [4:0] S_X_MUL     = 5'd16;
    localparam logic [4:0] S_X         = 5'd17;
    localparam logic [4:0] S_Y         = 5'd18;
    localparam logic [4:0] S_OUT       = 5'd19;

    logic [4:0]         r_state;
    logic [4:0]         n_state;
    logic               r_phase;
    t_odo_in            r_in;
    logic [30:0]        r_wb;
    logic [24:0]        r_cti;
    logic signed [31:0] r_last_l, r_last_r;
    logic signed [32:0] r_dl, r_dr;
    logic signed [31:0] r_ld, r_rd, r_tl, r_tr;
    logic signed [31:0] r_arc, r_prev;
    logic signed [32:0] r_da;
    logic signed [34:0] r_targ;
    logic [34:0]        r_red;
    logic               r_red_neg;
    logic [2:0]         r_k;
    logic signed [31:0] r_z;
    logic               r_neg;
    logic signed [33:0] r_cx, r_cy, r_c, r_s;
    logic [IW-1:0]      r_i;
    logic signed [34:0] r_chord;
    logic signed [31:0] r_fwd;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_px, r_py, r_ph;
    t_odo_out           r_out;
    logic               r_out_valid;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic               in_xfer;
    logic               out_free;
    logic signed [32:0] lsum, rsum;
    logic signed [31:0] lavg, ravg;
    logic [30:0]        wb_eff;
    logic signed [34:0] mul_a, mul_b;
    logic               mul_en;
    logic signed [31:0] side;
    logic signed [64:0] side_rnd;
    logic signed [32:0] half_da;
    logic signed [32:0] lr_sum, half_lr;
    logic signed [31:0] arc_new;
    logic [34:0]        red_mod, red_sub, red_next;
    logic               red_take;
    logic signed [31:0] z0, z1, z2, z3;
    logic               fold_neg;
    logic signed [33:0] dx, dy;
    logic signed [33:0] at;
    logic signed [33:0] cf, sf;
    logic signed [64:0] fwd_diff;
    logic signed [64:0] pose_rnd;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign lsum   = 33'(r_in.left_front_count) + 33'(r_in.left_back_count);
    assign rsum   = 33'(r_in.right_front_count) + 33'(r_in.right_back_count);
    assign lavg   = lsum[32:1];
    assign ravg   = rsum[32:1];
    assign wb_eff = (r_wb == '0) ? 31'd1 : r_wb;

    assign side_rnd = (65'(r_prod) + 65'sd128) >>> 8;
    assign side     = sat32(72'(side_rnd));
    assign half_da  = (r_da + $signed({32'b0, r_da[32]})) >>> 1;
    assign lr_sum   = 33'(r_ld) + 33'(r_rd);
    assign half_lr  = (lr_sum + $signed({32'b0, lr_sum[32]})) >>> 1;
    assign arc_new  = sat32(72'(div_rsp.quot));
    assign fwd_diff = 65'(div_rsp.quot) - 65'(r_prod >>> 31);
    assign pose_rnd = (65'(r_prod) + 65'sd536870912) >>> 30;

    // one restoring step of the angle magnitude against 2*pi shifted by r_k
    assign red_mod  = TWO_PI_W << r_k;
    assign red_take = (r_red >= red_mod);
    assign red_sub  = r_red - red_mod;
    assign red_next = red_take ? red_sub : r_red;

    // angle reduction fold into [-pi/2, pi/2]
    always_comb begin
        z0 = 32'(red_next);
        if (r_red_neg) begin
            z0 = -z0;
        end
        z1 = (z0 > PI_Q24) ? z0 - TWO_PI_Q24 : z0;
        z2 = (z1 < -PI_Q24) ? z1 + TWO_PI_Q24 : z1;
        fold_neg = 1'b0;
        z3 = z2;
        if (z2 > HALF_PI_Q24) begin
            z3 = z2 - PI_Q24;
            fold_neg = 1'b1;
        end else if (z2 < -HALF_PI_Q24) begin
            z3 = z2 + PI_Q24;
            fold_neg = 1'b1;
        end
    end

    assign dx = r_cy >>> r_i;
    assign dy = r_cx >>> r_i;
    assign at = 34'(atan_step(5'(r_i)));
    assign cf = r_neg ? -r_cx : r_cx;
    assign sf = r_neg ? -r_cy : r_cy;

    always_comb begin
        mul_en = 1'b1;
        case (r_state)
            S_MUL_L: begin
                mul_a = 35'(r_dl);
                mul_b = $signed({10'b0, r_cti});
            end
            S_MUL_R: begin
                mul_a = 35'(r_dr);
                mul_b = $signed({10'b0, r_cti});
            end
            S_CH_MUL: begin
                mul_a = 35'(r_rd);
                mul_b = r_chord;
            end
            S_CH_GO: begin
                mul_a = r_chord;
                mul_b = $signed({4'b0, wb_eff});
            end
            S_X_MUL: begin
                mul_a = 35'(r_fwd);
                mul_b = 35'(r_s);
            end
            S_X: begin
                mul_a = 35'(r_fwd);
                mul_b = 35'(r_c);
            end
            default: begin
                mul_a  = '0;
                mul_b  = '0;
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        case (r_state)
            S_ARC_GO: begin
                div_req.start = 1'b1;
                div_req.num   = 64'(33'(r_tr) - 33'(r_tl)) <<< 24;
                div_req.den   = $signed({10'b0, wb_eff});
            end
            S_CH_GO: begin
                div_req.start = 1'b1;
                div_req.num   = r_prod;
                div_req.den   = 41'(r_da) <<< 6;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (in_xfer) begin
                n_state = (i_in_data.kind == KIND_TICK) ? S_AVG : S_OUT;
            end
            S_AVG:       n_state = S_MUL_L;
            S_MUL_L:     n_state = S_MUL_R;
            S_MUL_R:     n_state = S_DIST_R;
            S_DIST_R:    n_state = S_ARC_GO;
            S_ARC_GO:    n_state = S_ARC_WAIT;
            S_ARC_WAIT:  if (div_rsp.done) begin
                n_state = S_ANGLE;
            end
            S_ANGLE:     n_state = (r_da == '0) ? S_POSE_TRIG : S_TRIG_GO;
            S_TRIG_GO:   n_state = S_TRIG_WAIT;
            S_TRIG_WAIT: if (r_k == 3'd0) begin
                n_state = S_CORDIC;
            end
            S_CORDIC:    if (r_i == IW'(CORDIC_STEPS - 1)) begin
                n_state = S_TRIG_END;
            end
            S_TRIG_END:  n_state = r_phase ? S_X_MUL : S_CH_MUL;
            S_CH_MUL:    n_state = S_CH_GO;
            S_CH_GO:     n_state = S_CH_WAIT;
            S_CH_WAIT:   if (div_rsp.done) begin
                n_state = S_POSE_TRIG;
            end
            S_POSE_TRIG: n_state = S_TRIG_GO;
            S_X_MUL:     n_state = S_X;
            S_X:         n_state = S_Y;
            S_Y:         n_state = S_OUT;
            S_OUT:       if (out_free) begin
                n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // control and stored state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wb        <= WHEELBASE_RST;
            r_cti       <= COUNT_TO_INCH_RST;
            r_last_l    <= '0;
            r_last_r    <= '0;
            r_tl        <= '0;
            r_tr        <= '0;
            r_arc       <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_ph        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_WHEELBASE) begin
                    r_wb <= i_cfg_data[30:0];
                end else if (i_cfg_index == CFG_COUNT_TO_INCH) begin
                    r_cti <= i_cfg_data[24:0];
                end
            end
            case (r_state)
                S_IDLE: if (in_xfer) begin
                    if (i_in_data.kind == KIND_SET) begin
                        r_px <= i_in_data.new_x;
                        r_py <= i_in_data.new_y;
                        r_ph <= i_in_data.new_heading;
                    end else if (i_in_data.kind == KIND_CLR) begin
                        r_last_l <= '0;
                        r_last_r <= '0;
                        r_tl     <= '0;
                        r_tr     <= '0;
                        r_arc    <= '0;
                        r_px     <= '0;
                        r_py     <= '0;
                        r_ph     <= '0;
                    end
                end
                S_AVG: begin
                    r_last_l <= lavg;
                    r_last_r <= ravg;
                end
                S_MUL_R:  r_tl <= sat32(72'(r_tl) + 72'(side));
                S_DIST_R: r_tr <= sat32(72'(r_tr) + 72'(side));
                S_ARC_WAIT: if (div_rsp.done) begin
                    r_arc <= arc_new;
                end
                S_X: r_px <= sat32(72'(r_px) + 72'(pose_rnd));
                S_Y: begin
                    r_py <= sat32(72'(r_py) + 72'(pose_rnd));
                    r_ph <= sat32(72'(r_ph) + 72'(r_da));
                end
                default: begin
                end
            endcase
        end
    end

    // datapath working registers
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= 64'(mul_a * mul_b);
        end
        case (r_state)
            S_IDLE: if (in_xfer) begin
                r_in <= i_in_data;
                r_da <= '0;
            end
            S_AVG: begin
                r_dl <= 33'(lavg) - 33'(r_last_l);
                r_dr <= 33'(ravg) - 33'(r_last_r);
            end
            S_MUL_R:  r_ld <= side;
            S_DIST_R: r_rd <= side;
            S_ARC_WAIT: if (div_rsp.done) begin
                r_prev <= r_arc;
                r_da   <= 33'(arc_new) - 33'(r_arc);
            end
            S_ANGLE: begin
                r_phase <= 1'b0;
                r_targ  <= 35'(half_da);
                r_fwd   <= half_lr[31:0];
            end
            S_TRIG_GO: begin
                r_red     <= r_targ[34] ? 35'(-r_targ) : 35'(r_targ);
                r_red_neg <= r_targ[34];
                r_k       <= 3'd7;
            end
            S_TRIG_WAIT: begin
                if (r_k == 3'd0) begin
                    r_z   <= z3;
                    r_neg <= fold_neg;
                    r_cx  <= CORDIC_GAIN_Q30;
                    r_cy  <= '0;
                    r_i   <= '0;
                end else begin
                    r_red <= red_next;
                    r_k   <= r_k - 1'b1;
                end
            end
            S_CORDIC: begin
                if (r_z >= 0) begin
                    r_cx <= r_cx - dx;
                    r_cy <= r_cy + dy;
                    r_z  <= r_z - 32'(at);
                end else begin
                    r_cx <= r_cx + dx;
                    r_cy <= r_cy - dy;
                    r_z  <= r_z + 32'(at);
                end
                r_i <= r_i + 1'b1;
            end
            S_TRIG_END: begin
                r_c     <= cf;
                r_s     <= sf;
                r_chord <= 35'(sf) <<< 1;
            end
            S_CH_WAIT: if (div_rsp.done) begin
                r_fwd <= sat32(72'(fwd_diff));
            end
            S_POSE_TRIG: begin
                r_phase <= 1'b1;
                r_targ  <= -(35'(r_prev) + 35'(half_da));
            end
            S_OUT: if (out_free) begin
                r_out.pos_x   <= r_px;
                r_out.pos_y   <= r_py;
                r_out.heading <= r_ph;
            end
            default: begin
            end
        endcase
    end

    odo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input accepted while an item is in flight");

    a_state_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= S_OUT)
        else $error("sequencer in an undefined state");

endmodule
